// ----- rtl/erm_pkg.sv -----
package erm_pkg;

    // fixed-point formats of the datapath
    localparam int ANG_W   = 16;
    localparam int OUT_W   = 16;
    localparam int Q_W     = 32;
    localparam int ATAN_LEN = 30;

    // angle reduction, degrees times 64
    localparam logic signed [16:0] FULL_TURN    = 17'sd23040;
    localparam logic signed [16:0] HALF_TURN    = 17'sd11520;
    localparam logic signed [16:0] QUARTER_TURN = 17'sd5760;

    // pi in Q30 split as pi_q30 = PI_QUO * 11520 + PI_REM
    localparam logic [18:0] PI_QUO     = 19'd292817;
    localparam logic [12:0] PI_REM     = 13'd7586;
    localparam logic [12:0] HALF_DIV   = 13'd5760;
    // ceil(2^24 / 45), exact for 18-bit dividends
    localparam logic [18:0] RECIP_45   = 19'd372828;

    localparam logic signed [Q_W-1:0] INV_GAIN = 32'sd652032874;

    typedef logic signed [Q_W-1:0] t_q30;

    typedef struct packed {
        logic signed [ANG_W-1:0] phi_angle;
        logic signed [ANG_W-1:0] theta_angle;
        logic signed [ANG_W-1:0] psi_angle;
    } t_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] m00;
        logic signed [OUT_W-1:0] m10;
        logic signed [OUT_W-1:0] m20;
        logic signed [OUT_W-1:0] m01;
        logic signed [OUT_W-1:0] m11;
        logic signed [OUT_W-1:0] m21;
        logic signed [OUT_W-1:0] m02;
        logic signed [OUT_W-1:0] m12;
        logic signed [OUT_W-1:0] m22;
    } t_out;

    // truncated atan(2^-i) in Q30
    function automatic t_q30 atan_q30(input int idx);
        t_q30 v;
        case (idx)
            0:  v = 32'sh3243F6A8;
            1:  v = 32'sh1DAC6705;
            2:  v = 32'sh0FADBAFC;
            3:  v = 32'sh07F56EA6;
            4:  v = 32'sh03FEAB76;
            5:  v = 32'sh01FFD55B;
            6:  v = 32'sh00FFFAAA;
            7:  v = 32'sh007FFF55;
            8:  v = 32'sh003FFFEA;
            9:  v = 32'sh001FFFFD;
            10: v = 32'sh000FFFFF;
            11: v = 32'sh0007FFFF;
            12: v = 32'sh0003FFFF;
            13: v = 32'sh0001FFFF;
            14: v = 32'sh0000FFFF;
            15: v = 32'sh00007FFF;
            16: v = 32'sh00003FFF;
            17: v = 32'sh00001FFF;
            18: v = 32'sh00000FFF;
            19: v = 32'sh000007FF;
            20: v = 32'sh000003FF;
            21: v = 32'sh000001FF;
            22: v = 32'sh000000FF;
            23: v = 32'sh0000007F;
            24: v = 32'sh0000003F;
            25: v = 32'sh0000001F;
            26: v = 32'sh0000000F;
            27: v = 32'sh00000007;
            28: v = 32'sh00000003;
            29: v = 32'sh00000001;
            default: v = '0;
        endcase
        return v;
    endfunction

    // q30 product with round half up: floor((a*b + 2^29) / 2^30)
    function automatic t_q30 qmul(input t_q30 a, input t_q30 b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b) + 64'sd536870912;
        return p[61:30];
    endfunction

endpackage

// ----- rtl/erm_sincos.sv -----
module erm_sincos #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [erm_pkg::ANG_W-1:0]  i_angle,
    output erm_pkg::t_q30                     o_cos,
    output erm_pkg::t_q30                     o_sin
);

    // stage a: reduce modulo a full turn, fold into +-90 degrees
    logic signed [16:0] w_a;
    logic signed [16:0] w_r;
    logic signed [16:0] w_f;
    logic               w_flip;
    logic signed [16:0] w_mag;

    always_comb begin
        w_a = 17'(i_angle);
        if (w_a >= erm_pkg::HALF_TURN) begin
            w_r = w_a - erm_pkg::FULL_TURN;
        end else if (w_a < -erm_pkg::HALF_TURN) begin
            w_r = w_a + erm_pkg::FULL_TURN;
        end else begin
            w_r = w_a;
        end
        w_flip = 1'b0;
        w_f    = w_r;
        if (w_r > erm_pkg::QUARTER_TURN) begin
            w_f    = w_r - erm_pkg::HALF_TURN;
            w_flip = 1'b1;
        end else if (w_r < -erm_pkg::QUARTER_TURN) begin
            w_f    = w_r + erm_pkg::HALF_TURN;
            w_flip = 1'b1;
        end
        w_mag = w_f[16] ? -w_f : w_f;
    end

    logic [12:0] r_a_mag;
    logic        r_a_neg;
    logic        r_a_flip;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_mag  <= w_mag[12:0];
            r_a_neg  <= w_f[16];
            r_a_flip <= w_flip;
        end
    end

    // stage b: split degrees-to-radians product into quotient and remainder parts
    logic [31:0] r_b_p1;
    logic [25:0] r_b_n;
    logic        r_b_neg;
    logic        r_b_flip;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_p1   <= 32'(r_a_mag) * 32'(erm_pkg::PI_QUO);
            r_b_n    <= 26'(r_a_mag) * 26'(erm_pkg::PI_REM) + 26'(erm_pkg::HALF_DIV);
            r_b_neg  <= r_a_neg;
            r_b_flip <= r_a_flip;
        end
    end

    // stage c: divide the remainder part by 11520 as >>8 then reciprocal of 45
    logic [36:0] w_c_prod;
    logic [31:0] w_c_z;

    always_comb begin
        w_c_prod = 37'(r_b_n[25:8]) * 37'(erm_pkg::RECIP_45);
        w_c_z    = r_b_p1 + 32'(w_c_prod[36:24]);
    end

    erm_pkg::t_q30 r_x [0:CORDIC_STEPS];
    erm_pkg::t_q30 r_y [0:CORDIC_STEPS];
    erm_pkg::t_q30 r_z [0:CORDIC_STEPS];
    logic          r_flip [0:CORDIC_STEPS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= erm_pkg::INV_GAIN;
            r_y[0]    <= '0;
            r_z[0]    <= r_b_neg ? -$signed(w_c_z) : $signed(w_c_z);
            r_flip[0] <= r_b_flip;
        end
    end

    // one rotation step per stage, sign flip folded into the last one
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        erm_pkg::t_q30 w_dx, w_dy, w_x, w_y, w_z;

        always_comb begin
            w_dx = r_y[i] >>> i;
            w_dy = r_x[i] >>> i;
            if (!r_z[i][erm_pkg::Q_W-1]) begin
                w_x = r_x[i] - w_dx;
                w_y = r_y[i] + w_dy;
                w_z = r_z[i] - erm_pkg::atan_q30(i);
            end else begin
                w_x = r_x[i] + w_dx;
                w_y = r_y[i] - w_dy;
                w_z = r_z[i] + erm_pkg::atan_q30(i);
            end
            if (i == CORDIC_STEPS - 1 && r_flip[i]) begin
                w_x = -w_x;
                w_y = -w_y;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[i+1]    <= w_x;
                r_y[i+1]    <= w_y;
                r_z[i+1]    <= w_z;
                r_flip[i+1] <= r_flip[i];
            end
        end
    end

    assign o_cos = r_x[CORDIC_STEPS];
    assign o_sin = r_y[CORDIC_STEPS];

endmodule

// ----- rtl/euler_zxz_rotation_matrix.sv -----
// ZXZ Euler-angle rotation matrix, R = Rz(phi) * Rx(theta) * Rz(psi).
//
// input channel: i_valid / o_stall with i_data carrying phi, theta and psi
// in degrees times 64 (any 16-bit value, reduced modulo 360 degrees).
// output channel: o_valid / i_stall with o_data carrying the nine matrix
// entries, signed with FRAC_BITS fraction bits, saturated to +-1.0.
// a transaction moves on a rising edge with valid high and stall low.
//
// the pipeline has three stages of angle reduction, one stage per CORDIC
// step, two product stages and one stage of summing and rounding that is
// also the output register. throughput is one transaction per cycle
// while the receiver does not stall; every stage moves together.
//
// reset clears all valid bits; the data registers are not reset.
// when the receiver stalls a valid output, the whole pipeline holds and
// o_stall rises; empty outputs never stall the input.
module euler_zxz_rotation_matrix #(
    parameter int CORDIC_STEPS = 16,
    parameter int FRAC_BITS    = 14
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  erm_pkg::t_in   i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output erm_pkg::t_out  o_data
);

    localparam int LAT = CORDIC_STEPS + 6;
    localparam int SH  = 30 - FRAC_BITS;
    localparam int SHM = (SH > 0) ? SH - 1 : 0;
    localparam logic signed [33:0] RND = (SH > 0) ? (34'sd1 <<< SHM) : 34'sd0;
    localparam logic signed [33:0] LIM = 34'sd1 <<< FRAC_BITS;

    logic           w_en;
    logic [LAT-1:0] r_vld;

    assign w_en    = !r_vld[LAT-1] || !i_stall;
    assign o_stall = !w_en;
    assign o_valid = r_vld[LAT-1];

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // sine and cosine of each angle
    erm_pkg::t_q30 w_cf, w_sf, w_ct, w_st, w_cs, w_ss;

    erm_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_phi (
        .i_clk(i_clk), .i_en(w_en), .i_angle(i_data.phi_angle),
        .o_cos(w_cf), .o_sin(w_sf)
    );
    erm_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_theta (
        .i_clk(i_clk), .i_en(w_en), .i_angle(i_data.theta_angle),
        .o_cos(w_ct), .o_sin(w_st)
    );
    erm_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_psi (
        .i_clk(i_clk), .i_en(w_en), .i_angle(i_data.psi_angle),
        .o_cos(w_cs), .o_sin(w_ss)
    );

    // first product stage
    erm_pkg::t_q30 r_cfcs, r_ctsf, r_cfct, r_ctcs, r_cssf, r_stss, r_csst;
    erm_pkg::t_q30 r_sfst, r_cfst, r_cfss, r_sfss, r_p1_ss, r_p1_sf, r_p1_cs, r_p1_ct;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cfcs  <= erm_pkg::qmul(w_cf, w_cs);
            r_ctsf  <= erm_pkg::qmul(w_ct, w_sf);
            r_cfct  <= erm_pkg::qmul(w_cf, w_ct);
            r_ctcs  <= erm_pkg::qmul(w_ct, w_cs);
            r_cssf  <= erm_pkg::qmul(w_cs, w_sf);
            r_stss  <= erm_pkg::qmul(w_st, w_ss);
            r_csst  <= erm_pkg::qmul(w_cs, w_st);
            r_sfst  <= erm_pkg::qmul(w_sf, w_st);
            r_cfst  <= erm_pkg::qmul(w_cf, w_st);
            r_cfss  <= erm_pkg::qmul(w_cf, w_ss);
            r_sfss  <= erm_pkg::qmul(w_sf, w_ss);
            r_p1_ss <= w_ss;
            r_p1_sf <= w_sf;
            r_p1_cs <= w_cs;
            r_p1_ct <= w_ct;
        end
    end

    // second product stage for the triple products
    erm_pkg::t_q30 r_ctsfss, r_cfctss, r_ctcssf, r_cfctcs;
    erm_pkg::t_q30 r2_cfcs, r2_cssf, r2_stss, r2_csst, r2_sfst, r2_cfst, r2_cfss;
    erm_pkg::t_q30 r2_sfss, r2_ct;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ctsfss <= erm_pkg::qmul(r_ctsf, r_p1_ss);
            r_cfctss <= erm_pkg::qmul(r_cfct, r_p1_ss);
            r_ctcssf <= erm_pkg::qmul(r_ctcs, r_p1_sf);
            r_cfctcs <= erm_pkg::qmul(r_cfct, r_p1_cs);
            r2_cfcs  <= r_cfcs;
            r2_cssf  <= r_cssf;
            r2_stss  <= r_stss;
            r2_csst  <= r_csst;
            r2_sfst  <= r_sfst;
            r2_cfst  <= r_cfst;
            r2_cfss  <= r_cfss;
            r2_sfss  <= r_sfss;
            r2_ct    <= r_p1_ct;
        end
    end

    // round to the output format and saturate to +-1.0
    function automatic logic signed [15:0] to_out(input logic signed [33:0] v);
        logic signed [33:0] t;
        t = (v + RND) >>> SH;
        if (t > LIM) begin
            t = LIM;
        end else if (t < -LIM) begin
            t = -LIM;
        end
        return t[15:0];
    endfunction

    // sums and output register
    erm_pkg::t_out n_out;
    erm_pkg::t_out r_out;

    always_comb begin
        n_out.m00 = to_out(34'(r2_cfcs) - 34'(r_ctsfss));
        n_out.m10 = to_out(34'(r2_cssf) + 34'(r_cfctss));
        n_out.m20 = to_out(34'(r2_stss));
        n_out.m01 = to_out(-34'(r2_cfss) - 34'(r_ctcssf));
        n_out.m11 = to_out(34'(r_cfctcs) - 34'(r2_sfss));
        n_out.m21 = to_out(34'(r2_csst));
        n_out.m02 = to_out(34'(r2_sfst));
        n_out.m12 = to_out(-34'(r2_cfst));
        n_out.m22 = to_out(34'(r2_ct));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_data = r_out;

endmodule

// ----- rtl/erm_checker.sv -----
module erm_props (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           o_stall,
    input  erm_pkg::t_in   i_data,
    input  logic           o_valid,
    input  logic           i_stall,
    input  erm_pkg::t_out  o_data
);

    // reset empties the pipeline
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // a stalled result stays and holds its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled result changed");

    // an empty output never backs up the input
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with empty output");

    // input stalls only while the receiver stalls
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> i_stall)
        else $error("input stalled without output stall");

endmodule

bind euler_zxz_rotation_matrix erm_props u_erm_props (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_valid(i_valid),
    .o_stall(o_stall),
    .i_data(i_data),
    .o_valid(o_valid),
    .i_stall(i_stall),
    .o_data(o_data)
);
